### design/assert_macros.svh
// assertion macro used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a property holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

### design/fpr_pkg.sv
// package for the false position root finder: types, constants, codes
// no dependencies
`default_nettype none
package fpr_pkg;
  localparam int unsigned NumCoeffsDef = 4;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned NumRegs      = 6;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [CfgIdxW-1:0] RegCoeff0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoeff1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoeff2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoeff3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTol    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMaxIt  = 3'd5;

  localparam logic [1:0] StatConverged = 2'd0;
  localparam logic [1:0] StatLimit     = 2'd1;
  localparam logic [1:0] StatZeroDen   = 2'd2;

  typedef struct packed {
    logic signed [31:0] left_end;
    logic signed [31:0] right_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] root;
    logic signed [31:0] residual;
    logic [7:0]         iterations_used;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EVAL_L,     // f(left)
    S_WAIT_L,
    S_EVAL_R,     // f(right)
    S_WAIT_R,
    S_CHECK_DEN,
    S_MUL_NUM,    // (r-l)*fr
    S_DIV_START,
    S_DIV_WAIT,
    S_XM,
    S_EVAL_M,
    S_WAIT_M,
    S_UPDATE,
    S_OUT
  } state_e;

  // datapath commands
  typedef struct packed {
    logic load;        // capture input bracket
    logic eval_start;  // start poly evaluation
    logic [1:0] eval_sel; // 0 left, 1 right, 2 xm
    logic store_fl;
    logic store_fr;
    logic mul_num;
    logic div_start;
    logic calc_xm;
    logic store_fm;
    logic update;
    logic set_zero_den;
  } cmd_t;

  localparam logic [1:0] SelLeft  = 2'd0;
  localparam logic [1:0] SelRight = 2'd1;
  localparam logic [1:0] SelMid   = 2'd2;

  typedef struct packed {
    logic eval_done;
    logic div_done;
    logic den_zero;
    logic stop_conv;
    logic stop_limit;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

### design/fpr_poly.sv
// horner evaluator of the configured polynomial; each step registers the product, then adds the next coefficient
// depends on fpr_pkg
`default_nettype none
module fpr_poly #(
  parameter int unsigned NUM_COEFFS = 4,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] coeff_i [4],
  output logic                    done_o,
  output logic signed [31:0]      y_o
);
  import fpr_pkg::*;
  localparam int unsigned IdxW = $clog2(NUM_COEFFS);

  logic busy_q, busy_d, ph_q, ph_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic signed [31:0] x_q, acc_q, acc_d;
  logic signed [63:0] prod_q;
  logic signed [31:0] cnext;
  logic signed [31:0] shifted;
  logic [IdxW-1:0] idx_m1;

  function automatic logic signed [31:0] coef_at(input logic [IdxW-1:0] i);
    if (32'(i) < 32'd4) return coeff_i[2'(i)];
    return '0;
  endfunction

  assign idx_m1 = idx_q - IdxW'(1);
  assign cnext  = coef_at(idx_m1);
  assign shifted = sat32(66'(prod_q >>> FRAC_BITS));

  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    idx_d  = idx_q;
    acc_d  = acc_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      ph_d   = 1'b0;
      idx_d  = IdxW'(NUM_COEFFS - 1);
      acc_d  = coef_at(IdxW'(NUM_COEFFS - 1));
    end else if (busy_q) begin
      if (ph_q) begin
        acc_d = sat32(66'(shifted) + 66'(cnext));
        idx_d = idx_m1;
        ph_d  = 1'b0;
        if (idx_m1 == '0) begin
          busy_d = 1'b0;
        end
      end else begin
        ph_d = 1'b1;
      end
    end
    if (busy_q && !ph_q && idx_q == '0) begin
      busy_d = 1'b0;
      done_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d | (busy_q && ph_q && idx_m1 == '0);
      ph_q   <= ph_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) x_q <= x_i;
    acc_q  <= acc_d;
    prod_q <= 64'(acc_q) * 64'(x_q);
  end

  assign y_o = acc_q;
endmodule
`default_nettype wire

### design/fpr_div.sv
// restoring divider, 66-bit signed quotient truncated toward zero
// depends on fpr_pkg
`default_nettype none
module fpr_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [65:0] num_i,
  input  wire logic signed [33:0] den_i,
  output logic                    done_o,
  output logic signed [65:0]      quo_o
);
  import fpr_pkg::*;
  logic busy_q;
  logic [6:0] cnt_q;
  logic [65:0] q_q, rem_q;
  logic [33:0] dabs_q;
  logic neg_q;
  logic [66:0] trial;

  assign trial = {rem_q, q_q[65]} - 67'(dabs_q);
  assign done_o = busy_q && cnt_q == 7'd0;
  assign quo_o  = neg_q ? -$signed(q_q) : $signed(q_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd66;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q    <= num_i[65] ? 66'(-num_i) : num_i;
      dabs_q <= den_i[33] ? 34'(-den_i) : den_i;
      neg_q  <= num_i[65] ^ den_i[33];
      rem_q  <= '0;
    end else if (busy_q && cnt_q != 7'd0) begin
      if (!trial[66]) begin
        rem_q <= trial[65:0];
        q_q   <= {q_q[64:0], 1'b1};
      end else begin
        rem_q <= {rem_q[64:0], q_q[65]};
        q_q   <= {q_q[64:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### design/fpr_datapath.sv
// datapath: bracket registers, shared evaluator, divider, result item
// depends on fpr_pkg, fpr_poly, fpr_div
`default_nettype none
module fpr_datapath #(
  parameter int unsigned NUM_COEFFS = 4,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fpr_pkg::cmd_t       cmd_i,
  output fpr_pkg::sts_t            sts_o,
  input  wire fpr_pkg::in_item_t   in_i,
  input  wire logic signed [31:0]  coeff_i [4],
  input  wire logic [30:0]         tol_i,
  input  wire logic [7:0]          max_it_i,
  output fpr_pkg::out_item_t       out_o
);
  import fpr_pkg::*;
  logic signed [31:0] l_q, r_q, fl_q, fr_q, xm_q, fm_q, root_q, res_q;
  logic [7:0] it_q;
  logic [1:0] stat_q;
  logic signed [65:0] num_q, quo;
  logic signed [31:0] ex, ey;
  logic signed [33:0] den;
  logic signed [33:0] stp;
  logic [33:0] stp_abs;
  logic e_done, d_done;
  logic [7:0] lim;

  always_comb begin
    case (cmd_i.eval_sel)
      SelLeft:  ex = l_q;
      SelRight: ex = r_q;
      default:  ex = xm_q;
    endcase
  end

  fpr_poly #(.NUM_COEFFS(NUM_COEFFS), .FRAC_BITS(FRAC_BITS)) u_poly (
    .clk_i, .rst_ni, .start_i(cmd_i.eval_start), .x_i(ex), .coeff_i,
    .done_o(e_done), .y_o(ey));

  assign den = 34'(fr_q) - 34'(fl_q);

  fpr_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(num_q), .den_i(den),
    .done_o(d_done), .quo_o(quo));

  assign stp     = 34'(xm_q) - 34'(l_q);
  assign stp_abs = stp[33] ? 34'(-stp) : stp;
  assign lim     = (max_it_i == 8'd0) ? 8'd1 : max_it_i;

  assign sts_o.eval_done  = e_done;
  assign sts_o.div_done   = d_done;
  assign sts_o.den_zero   = den == '0;
  assign sts_o.stop_conv  = stp_abs <= 34'(tol_i);
  assign sts_o.stop_limit = it_q >= lim;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_q    <= in_i.left_end;
      r_q    <= in_i.right_end;
      it_q   <= '0;
      stat_q <= StatLimit;
    end
    if (cmd_i.store_fl) fl_q <= ey;
    if (cmd_i.store_fr) begin
      fr_q <= ey;
      root_q <= r_q;
      res_q <= ey;
    end
    if (cmd_i.mul_num) num_q <= 66'(34'(r_q) - 34'(l_q)) * 66'(fr_q);
    if (cmd_i.calc_xm) xm_q <= sat32(66'(r_q) - quo);
    if (cmd_i.store_fm) begin
      fm_q <= ey;
      root_q <= xm_q;
      res_q <= ey;
      it_q <= it_q + 8'd1;
    end
    if (cmd_i.update) begin
      if (fm_q[31] == fl_q[31]) begin
        l_q <= xm_q; fl_q <= fm_q;
      end else begin
        r_q <= xm_q; fr_q <= fm_q;
      end
      if (sts_o.stop_conv) stat_q <= StatConverged;
    end
    if (cmd_i.set_zero_den) stat_q <= StatZeroDen;
  end

  assign out_o.root            = root_q;
  assign out_o.residual        = res_q;
  assign out_o.iterations_used = it_q;
  assign out_o.status          = stat_q;
endmodule
`default_nettype wire

### design/fpr_ctrl.sv
// controller state machine for the root finder iteration
// depends on fpr_pkg
`default_nettype none
module fpr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire fpr_pkg::sts_t sts_i,
  output fpr_pkg::cmd_t      cmd_o,
  output fpr_pkg::state_e    state_o
);
  import fpr_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_EVAL_L;
        end
      end
      S_EVAL_L: begin
        cmd_o.eval_start = 1'b1;
        cmd_o.eval_sel = SelLeft;
        state_d = S_WAIT_L;
      end
      S_WAIT_L: begin
        cmd_o.eval_sel = SelLeft;
        if (sts_i.eval_done) begin
          cmd_o.store_fl = 1'b1;
          state_d = S_EVAL_R;
        end
      end
      S_EVAL_R: begin
        cmd_o.eval_start = 1'b1;
        cmd_o.eval_sel = SelRight;
        state_d = S_WAIT_R;
      end
      S_WAIT_R: begin
        if (sts_i.eval_done) begin
          cmd_o.store_fr = 1'b1;
          state_d = S_CHECK_DEN;
        end
      end
      S_CHECK_DEN: begin
        if (sts_i.den_zero) begin
          cmd_o.set_zero_den = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.mul_num = 1'b1;
          state_d = S_MUL_NUM;
        end
      end
      S_MUL_NUM: state_d = S_DIV_START;
      S_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (sts_i.div_done) state_d = S_XM;
      S_XM: begin
        cmd_o.calc_xm = 1'b1;
        state_d = S_EVAL_M;
      end
      S_EVAL_M: begin
        cmd_o.eval_start = 1'b1;
        cmd_o.eval_sel = SelMid;
        state_d = S_WAIT_M;
      end
      S_WAIT_M: begin
        if (sts_i.eval_done) begin
          cmd_o.store_fm = 1'b1;
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (sts_i.stop_conv || sts_i.stop_limit) state_d = S_OUT;
        else state_d = S_CHECK_DEN;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign state_o = state_q;
endmodule
`default_nettype wire

### design/false_position_root_finder.sv
// false position root finder for a configured cubic, signed q16.16
// the search evaluates both end points, then each iteration runs the 66-step serial divider
// and a horner evaluation of the midpoint; a zero denominator ends the search early
// one item at a time; a new item is taken once the previous result is taken
// reset: asynchronous active low, registers return to coefficients -20,10,2,1,
// tolerance 66 and a limit of 64 iterations
`default_nettype none
`include "assert_macros.svh"
module false_position_root_finder #(
  parameter int unsigned NUM_COEFFS = fpr_pkg::NumCoeffsDef,
  parameter int unsigned FRAC_BITS  = fpr_pkg::FracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire fpr_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output fpr_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fpr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i
);
  import fpr_pkg::*;

  // configuration registers
  logic signed [31:0] coeff_q [4];
  logic [30:0] tol_q;
  logic [7:0]  max_it_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q[0] <= 32'(-20 * (1 << FRAC_BITS));
      coeff_q[1] <= 32'(10 * (1 << FRAC_BITS));
      coeff_q[2] <= 32'(2 * (1 << FRAC_BITS));
      coeff_q[3] <= 32'(1 << FRAC_BITS);
      tol_q      <= 31'd66;
      max_it_q   <= 8'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCoeff0: coeff_q[0] <= cfg_data_i;
        RegCoeff1: coeff_q[1] <= cfg_data_i;
        RegCoeff2: coeff_q[2] <= cfg_data_i;
        RegCoeff3: coeff_q[3] <= cfg_data_i;
        RegTol:    tol_q      <= cfg_data_i[30:0];
        RegMaxIt:  max_it_q   <= cfg_data_i[7:0];
        default: ;  // unused indexes ignored
      endcase
    end
  end

  cmd_t   cmd;
  sts_t   sts;
  state_e state;

  fpr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd), .state_o(state));

  fpr_datapath #(.NUM_COEFFS(NUM_COEFFS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_i(in_data_i),
    .coeff_i(coeff_q), .tol_i(tol_q), .max_it_i(max_it_q), .out_o(out_data_o));

  // an item is only taken while nothing is in flight
  `ASSERT_CLK(a_ready_idle, clk_i, rst_ni, in_ready_o |-> state == S_IDLE, "ready while busy")
  // result and input never offered together
  `ASSERT_CLK(a_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready and valid overlap")
  // an offered result never carries the unused status code
  `ASSERT_CLK(a_stat, clk_i, rst_ni, out_valid_o |-> out_data_o.status != 2'd3, "bad status")
endmodule
`default_nettype wire
